>>> src/rgb_to_hsl_converter_top_defines.svh
// Assertion macros for the converter
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");
`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");
`else
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/rhc_pkg.sv
package rhc_pkg;

    localparam int unsigned PIX_W     = 24;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned SUM_W     = 9;
    localparam int unsigned Q_W       = 16;
    localparam int unsigned HD_W      = 11;
    localparam int unsigned NUM_W     = 12;
    localparam int unsigned STEP_BITS = 4;
    localparam int unsigned DIV_STG   = Q_W / STEP_BITS;

    typedef struct packed {
        logic            gray;
        logic [Q_W-1:0]  light;
        logic [CH_W-1:0] s_div;
        logic [CH_W-1:0] s_rem;
        logic [Q_W-1:0]  s_low;
        logic [Q_W-1:0]  s_q;
        logic [HD_W-1:0] h_div;
        logic [HD_W-1:0] h_rem;
        logic [Q_W-1:0]  h_q;
    } t_div_stg;

endpackage

>>> src/rhc_pix_if.sv
interface rhc_pix_if
    import rhc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] color;

    modport source (output valid, output color, input ready);
    modport sink (input valid, input color, output ready);
endinterface

>>> src/rhc_hsl_if.sv
interface rhc_hsl_if
    import rhc_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] hue;
    logic [Q_W-1:0] saturation;
    logic [Q_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness, input ready);
    modport sink (input valid, input hue, input saturation, input lightness, output ready);
endinterface

>>> src/rgb_to_hsl_converter_top.sv
// RGB to HSL converter. Takes one 24-bit pixel per request and returns 16-bit hue,
// saturation and lightness; one pixel enters per clock unless output stall has filled
// every stage, and each result passes through an input register, a min/max stage, then
// four stages of two radix-2 dividers (saturation and hue) that each resolve four
// quotient bits. Every stage keeps its own valid bit and empty stages fill under
// output stall.
`include "rgb_to_hsl_converter_top_defines.svh"

module rgb_to_hsl_converter_top
    import rhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_pix_if.sink    i_pix,
    rhc_hsl_if.source  o_hsl
);

    logic             r_vc;
    logic [PIX_W-1:0] r_color;
    logic             r_v   [0:DIV_STG];
    t_div_stg         r_stg [0:DIV_STG];
    t_div_stg         n_stg [0:DIV_STG];
    logic             ce_st [0:DIV_STG];
    logic             ce_in;

    always_comb begin
        ce_st[DIV_STG] = !r_v[DIV_STG] || o_hsl.ready;
        for (int k = DIV_STG - 1; k >= 0; k--) begin
            ce_st[k] = !r_v[k] || ce_st[k+1];
        end
        ce_in = !r_vc || ce_st[0];
    end

    assign i_pix.ready = ce_in;

    always_comb begin
        logic [CH_W-1:0]         cr, cg, cb, mx, mn, d;
        logic [SUM_W-1:0]        sum;
        logic [PIX_W-1:0]        prod;
        logic signed [NUM_W-1:0] r12, g12, b12, d12, num;
        logic [CH_W:0]           s9;
        logic [HD_W:0]           h12;
        t_div_stg                t;

        cr = r_color[PIX_W-1 -: CH_W];
        cg = r_color[2*CH_W-1 -: CH_W];
        cb = r_color[CH_W-1:0];
        mx = cr;
        if (cg > mx) mx = cg;
        if (cb > mx) mx = cb;
        mn = cr;
        if (cg < mn) mn = cg;
        if (cb < mn) mn = cb;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};

        n_stg[0].gray  = (d == '0);
        n_stg[0].light = {sum, 7'b0} + {8'b0, sum[SUM_W-1:1]};
        n_stg[0].s_div = (sum < SUM_W'(255)) ? sum[CH_W-1:0] : CH_W'(SUM_W'(510) - sum);
        prod           = {d, 16'b0} - {16'b0, d};
        n_stg[0].s_rem = prod[PIX_W-1 -: CH_W];
        n_stg[0].s_low = prod[Q_W-1:0];
        n_stg[0].s_q   = '0;

        r12 = signed'({4'b0, cr});
        g12 = signed'({4'b0, cg});
        b12 = signed'({4'b0, cb});
        d12 = signed'({4'b0, d});
        if (cr == mx) begin
            num = g12 - b12;
        end else if (cg == mx) begin
            num = (d12 <<< 1) + b12 - r12;
        end else begin
            num = (d12 <<< 2) + r12 - g12;
        end
        if (num < 0) num = num + (d12 <<< 2) + (d12 <<< 1);
        n_stg[0].h_rem = num[HD_W-1:0];
        n_stg[0].h_div = ({3'b0, d} << 2) + ({3'b0, d} << 1);
        n_stg[0].h_q   = '0;

        for (int k = 1; k <= DIV_STG; k++) begin
            t = r_stg[k-1];
            for (int j = 0; j < STEP_BITS; j++) begin
                s9      = {t.s_rem, t.s_low[Q_W-1]};
                t.s_low = t.s_low << 1;
                if (s9 >= {1'b0, t.s_div}) begin
                    t.s_rem = CH_W'(s9 - {1'b0, t.s_div});
                    t.s_q   = {t.s_q[Q_W-2:0], 1'b1};
                end else begin
                    t.s_rem = s9[CH_W-1:0];
                    t.s_q   = {t.s_q[Q_W-2:0], 1'b0};
                end
                h12 = {t.h_rem, 1'b0};
                if (h12 >= {1'b0, t.h_div}) begin
                    t.h_rem = HD_W'(h12 - {1'b0, t.h_div});
                    t.h_q   = {t.h_q[Q_W-2:0], 1'b1};
                end else begin
                    t.h_rem = h12[HD_W-1:0];
                    t.h_q   = {t.h_q[Q_W-2:0], 1'b0};
                end
            end
            n_stg[k] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            for (int k = 0; k <= DIV_STG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (ce_in) r_vc <= i_pix.valid;
            if (ce_st[0]) r_v[0] <= r_vc;
            for (int k = 1; k <= DIV_STG; k++) begin
                if (ce_st[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce_in) r_color <= i_pix.color;
        for (int k = 0; k <= DIV_STG; k++) begin
            if (ce_st[k]) r_stg[k] <= n_stg[k];
        end
    end

    assign o_hsl.valid      = r_v[DIV_STG];
    assign o_hsl.hue        = r_stg[DIV_STG].gray ? '0 : r_stg[DIV_STG].h_q;
    assign o_hsl.saturation = r_stg[DIV_STG].gray ? '0 : r_stg[DIV_STG].s_q;
    assign o_hsl.lightness  = r_stg[DIV_STG].light;

    `RHC_ASSERT_IMP(a_sat_rem, i_clk, i_rst_n, r_v[DIV_STG] && !r_stg[DIV_STG].gray, r_stg[DIV_STG].s_rem < r_stg[DIV_STG].s_div)
    `RHC_ASSERT_IMP(a_hue_rem, i_clk, i_rst_n, r_v[DIV_STG] && !r_stg[DIV_STG].gray, r_stg[DIV_STG].h_rem < r_stg[DIV_STG].h_div)
    `RHC_ASSERT_NXT(a_req_lands, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_vc)
    `RHC_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_vc && r_v[0] && r_v[1] && r_v[2] && r_v[3] && r_v[DIV_STG] && !o_hsl.ready, !i_pix.ready)

endmodule

>>> bench/rgb_to_hsl_checker.sv
`timescale 1ns / 1ps

module rgb_to_hsl_checker
    import rhc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rhc_pix_if   i_pix,
    rhc_hsl_if   i_hsl,
    output int   o_mismatch_count,
    output int   o_pending
);

    typedef struct packed {
        logic [Q_W-1:0] hue;
        logic [Q_W-1:0] saturation;
        logic [Q_W-1:0] lightness;
    } t_hsl;

    t_hsl expected_hsl [$];
    int   mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_pending        = expected_hsl.size();

    function automatic t_hsl hsl_of_pixel(input logic [PIX_W-1:0] color);
        int   red;
        int   green;
        int   blue;
        int   hi;
        int   lo;
        int   span;
        int   sum;
        int   den;
        int   num;
        t_hsl res;
        red   = int'(color[2*CH_W +: CH_W]);
        green = int'(color[CH_W +: CH_W]);
        blue  = int'(color[0 +: CH_W]);
        hi = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        lo = red;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        span = hi - lo;
        sum  = hi + lo;
        res.lightness  = Q_W'((65535 * sum) / 510);
        res.saturation = '0;
        res.hue        = '0;
        if (span != 0) begin
            den = (sum < 255) ? sum : 510 - sum;
            res.saturation = Q_W'((65535 * span) / den);
            if (red == hi) begin
                num = green - blue;
            end else if (green == hi) begin
                num = 2 * span + (blue - red);
            end else begin
                num = 4 * span + (red - green);
            end
            if (num < 0) num += 6 * span;
            res.hue = Q_W'((num * 65536) / (6 * span));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int expected, input int actual);
        mismatch_count++;
        $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, expected, actual);
    endtask

    always @(posedge i_clk) begin : watch
        t_hsl oldest;
        if (i_rst_n) begin
            if (i_hsl.valid && i_hsl.ready) begin
                if (expected_hsl.size() == 0) begin
                    report_mismatch("result with no request, hue", 0, int'(i_hsl.hue));
                end else begin
                    oldest = expected_hsl.pop_front();
                    if (i_hsl.hue !== oldest.hue)
                        report_mismatch("hue", int'(oldest.hue), int'(i_hsl.hue));
                    if (i_hsl.saturation !== oldest.saturation)
                        report_mismatch("saturation", int'(oldest.saturation),
                                        int'(i_hsl.saturation));
                    if (i_hsl.lightness !== oldest.lightness)
                        report_mismatch("lightness", int'(oldest.lightness),
                                        int'(i_hsl.lightness));
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_hsl.push_back(hsl_of_pixel(i_pix.color));
            end
        end
    end

endmodule

>>> bench/rgb_to_hsl_converter_top_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsl_converter_top_tb;
    import rhc_pkg::*;

    localparam int RANDOM_PIXELS = 1000;
    localparam int HOLD_START    = 300;
    localparam int HOLD_LEN      = 300;
    localparam int STEADY_START  = 1200;
    localparam int STEADY_END    = 1700;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 24;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   quiet_cycles;

    rhc_pix_if pix_if ();
    rhc_hsl_if hsl_if ();

    rgb_to_hsl_converter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_hsl   (hsl_if)
    );

    rgb_to_hsl_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix            (pix_if),
        .i_hsl            (hsl_if),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (hsl_if.valid && hsl_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("** rgb_to_hsl_converter_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [CH_W-1:0] ch [3];
        logic [CH_W-1:0] levels [6];
        int kind;
        int hi;
        int first;
        int second;
        levels = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        kind = $urandom_range(99);
        if (kind < 55) begin
            return PIX_W'($urandom);
        end else if (kind < 70) begin
            ch[0] = CH_W'($urandom);
            return {ch[0], ch[0], ch[0]};
        end else if (kind < 85) begin
            hi = $urandom_range(255, 1);
            for (int i = 0; i < 3; i++) ch[i] = CH_W'($urandom_range(hi, 0));
            first  = $urandom_range(2);
            second = (first + 1 + $urandom_range(1)) % 3;
            ch[first]  = CH_W'(hi);
            ch[second] = CH_W'(hi);
        end else begin
            for (int i = 0; i < 3; i++) ch[i] = levels[$urandom_range(5)];
        end
        return {ch[0], ch[1], ch[2]};
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] color, input bit may_idle);
        while (may_idle && $urandom_range(99) < 10) begin
            pix_if.valid <= 1'b0;
            pix_if.color <= PIX_W'($urandom);
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.color <= color;
        do @(posedge i_clk); while (!pix_if.ready);
        @(negedge i_clk);
    endtask

    initial begin
        int cyc;
        cyc = 0;
        hsl_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
                hsl_if.ready <= 1'b0;
            end else if (cyc >= STEADY_START && cyc < STEADY_END) begin
                hsl_if.ready <= 1'b1;
            end else begin
                hsl_if.ready <= ($urandom_range(99) >= 10);
            end
        end
    end

    initial begin
        logic [PIX_W-1:0] directed [$];
        directed = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'h808080, 24'h7F7F7F, 24'hFF0080, 24'hFFFF00, 24'h00FFFF,
            24'hFF00FF, 24'h80807F, 24'h7F7F80, 24'hFE0000, 24'hFF0101,
            24'h010000, 24'h000001, 24'hFFFEFE, 24'h0080FF, 24'h00FF80,
            24'hFF8000, 24'h80FF00, 24'h8000FF, 24'h123456, 24'h7F0000
        };
        pix_if.valid = 1'b0;
        pix_if.color = '0;
        wait (i_rst_n);
        @(negedge i_clk);
        foreach (directed[i]) send_pixel(directed[i], 1'b1);
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            send_pixel(random_pixel(), !(i >= 500 && i < 700));
        end
        pix_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** rgb_to_hsl_converter_top: PASSED **");
        end else begin
            $display("** rgb_to_hsl_converter_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> rgb_to_hsl_converter_top.f
+incdir+src
src/rhc_pkg.sv
src/rhc_pix_if.sv
src/rhc_hsl_if.sv
src/rgb_to_hsl_converter_top.sv
bench/rgb_to_hsl_checker.sv
bench/rgb_to_hsl_converter_top_tb.sv
